/* design/egf_pkg.sv */
// Package for the gray emboss filter: register map, field widths, config struct.
// No dependencies; used by egf_cfg_regs and emboss_gray_filter.
`default_nettype none
package egf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int LEVEL_W  = 8;
    localparam int IWIDTH_W = 11;
    localparam int IHEIGHT_W = 13;
    localparam int CHAN_W   = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [CHAN_W-1:0] GRAY_MAX = 8'd255;

    typedef enum logic [1:0] {
        REG_GRAY_LEVEL   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   gray_level;
        logic [IWIDTH_W-1:0]  image_width;
        logic [IHEIGHT_W-1:0] image_height;
    } cfg_t;

endpackage
`default_nettype wire

/* design/egf_cfg_regs.sv */
// APB-style configuration registers of the gray emboss filter.
// Depends on egf_pkg (register indexes, cfg_t).
`default_nettype none
module egf_cfg_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [egf_pkg::APB_AW-1:0]  paddr,
    input  wire logic [egf_pkg::APB_DW-1:0]  pwdata,
    output logic      [egf_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output egf_pkg::cfg_t                    cfg
);

    egf_pkg::cfg_t     cfg_reg;
    egf_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = egf_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gray_level   <= '0;
            cfg_reg.image_width  <= egf_pkg::IWIDTH_W'(2);
            cfg_reg.image_height <= egf_pkg::IHEIGHT_W'(2);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                egf_pkg::REG_GRAY_LEVEL:
                    cfg_reg.gray_level <= pwdata[egf_pkg::LEVEL_W-1:0];
                egf_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= pwdata[egf_pkg::IWIDTH_W-1:0];
                egf_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[egf_pkg::IHEIGHT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            egf_pkg::REG_GRAY_LEVEL:
                prdata = egf_pkg::APB_DW'(cfg_reg.gray_level);
            egf_pkg::REG_IMAGE_WIDTH:
                prdata = egf_pkg::APB_DW'(cfg_reg.image_width);
            egf_pkg::REG_IMAGE_HEIGHT:
                prdata = egf_pkg::APB_DW'(cfg_reg.image_height);
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* design/egf_row_store.sv */
// Previous-row pixel store: single-port synchronous RAM, read-first, registered read.
// No dependencies.
`default_nettype none
module egf_row_store
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic      [31:0]   rdata
);

    logic [31:0] store_mem [DEPTH];
    logic [31:0] rdata_reg;

    // read-first: the old entry comes out while the new pixel goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg       <= store_mem[addr];
            store_mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/emboss_gray_filter.sv */
// Gray emboss filter. A pixel below row 0 passes the store read, the gray stage and the
// output register before its result transaction is offered; row-0 pixels give none.
// Throughput: one pixel per cycle while the output is not stalled; in the last row each
// pixel makes two output transactions, so there the single output register cannot take
// the next pixel before both results of the current one are accepted.
// Reset (rst_n, async low): counters, delay taps, pipeline valids and config registers
// cleared (level 0, 2x2 frame). Payload registers and the row store are not cleared;
// the row store has no clearing pass.
`default_nettype none
module emboss_gray_filter
#(
    parameter int MAX_WIDTH  = egf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = egf_pkg::MAX_HEIGHT_DEF,
    localparam int CW     = $clog2(MAX_WIDTH),
    localparam int RW     = $clog2(MAX_HEIGHT),
    localparam int OUT_DW = ((CW + RW + 16 + 7) / 8) * 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // pixel stream in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // red, green, blue, alpha
    // result stream out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [OUT_DW-1:0]           m_tdata,   // out_col, out_row, gray_value,
                                                        // alpha_out, zero pad
    output logic                             m_tlast,   // last_of_run
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [egf_pkg::APB_AW-1:0]  paddr,
    input  wire logic [egf_pkg::APB_DW-1:0]  pwdata,
    output logic      [egf_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int WCMP = (CW + 1 > egf_pkg::IWIDTH_W) ? CW + 1 : egf_pkg::IWIDTH_W;
    localparam int HCMP = (RW + 1 > egf_pkg::IHEIGHT_W) ? RW + 1 : egf_pkg::IHEIGHT_W;

    // max over r,g,b of |p-q|, plus level, saturated at 255
    function automatic logic [7:0] gray_of(input logic [23:0] p, input logic [23:0] q,
                                           input logic [7:0] level);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        logic [7:0] m;
        logic [8:0] sum;
        m = '0;
        for (int s = 0; s < 3; s++)
        begin
            a = p[s*8 +: 8];
            b = q[s*8 +: 8];
            d = (a > b) ? a - b : b - a;
            if (d > m)
                m = d;
        end
        sum = {1'b0, level} + {1'b0, m};
        return sum[8] ? egf_pkg::GRAY_MAX : sum[7:0];
    endfunction

    // ---------------- configuration ----------------
    egf_pkg::cfg_t cfg;

    egf_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective frame size, clamped to 2..MAX
    logic [WCMP-1:0] w_wide;
    logic [HCMP-1:0] h_wide;
    logic [CW:0]     w_eff;
    logic [RW:0]     h_eff;

    always_comb
    begin
        w_wide = WCMP'(cfg.image_width);
        if (w_wide < WCMP'(2))
            w_wide = WCMP'(2);
        else if (w_wide > WCMP'(MAX_WIDTH))
            w_wide = WCMP'(MAX_WIDTH);
        h_wide = HCMP'(cfg.image_height);
        if (h_wide < HCMP'(2))
            h_wide = HCMP'(2);
        else if (h_wide > HCMP'(MAX_HEIGHT))
            h_wide = HCMP'(MAX_HEIGHT);
        w_eff = w_wide[CW:0];
        h_eff = h_wide[RW:0];
    end

    // ---------------- pipeline handshake ----------------
    logic in_accept;
    logic s1_adv;
    logic s2_load;
    logic out_load;
    logic out_final;

    // ---------------- stage 0: position counters, store access ----------------
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic          row_is_last;
    logic          row_end;

    assign in_accept   = s_tvalid && s_tready;
    assign row_is_last = ({1'b0, row_count_reg} + (RW+1)'(1)) >= h_eff;
    assign row_end     = ({1'b0, col_count_reg} + (CW+1)'(1)) >= w_eff;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept)
        begin
            if (row_end)
            begin
                col_count_next = '0;
                row_count_next = row_is_last ? '0 : row_count_reg + RW'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    logic [31:0] old_pix;

    egf_row_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_store
    (
        .clk   (clk),
        .en    (in_accept),
        .addr  (col_count_reg),
        .wdata (s_tdata),
        .rdata (old_pix)
    );

    // ---------------- stage 1: gray of the row above ----------------
    logic          s1_valid_reg;
    logic [31:0]   s1_cur_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_emit_reg;   // row above exists
    logic          s1_last_reg;   // pixel is in the last row

    logic [31:0]   pd_reg [2];    // previous-row pixels displaced from the store
    logic [7:0]    gd_reg [2];    // last grays of row h-2
    logic          s1_near;       // column 0 or 1
    logic [31:0]   cmp_pix;
    logic [7:0]    g_above;
    logic [7:0]    g_ref;

    assign s1_near = s1_col_reg < CW'(2);
    assign cmp_pix = s1_near ? old_pix : pd_reg[1];
    assign g_above = gray_of(s1_cur_reg[23:0], cmp_pix[23:0], cfg.gray_level);
    assign g_ref   = s1_near ? g_above : gd_reg[1];

    // ---------------- stage 2: gray of the last row ----------------
    logic          s2_valid_reg;
    logic [23:0]   s2_rgb_reg;
    logic [7:0]    s2_alpha_cur_reg;
    logic [7:0]    s2_alpha_old_reg;
    logic [7:0]    s2_g_above_reg;
    logic [7:0]    s2_g_ref_reg;
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic          s2_last_reg;
    logic [7:0]    g_here;

    assign g_here = gray_of(s2_rgb_reg, {3{s2_g_ref_reg}}, cfg.gray_level);

    // ---------------- output register (one or two transactions) ----------------
    logic          out_valid_reg;
    logic          out_pair_reg;
    logic          out_phase_reg;    // 1 while the second result is shown
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_a_reg;
    logic [RW-1:0] out_row_b_reg;
    logic [7:0]    out_gray_a_reg;
    logic [7:0]    out_gray_b_reg;
    logic [7:0]    out_alpha_a_reg;
    logic [7:0]    out_alpha_b_reg;

    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = !out_pair_reg || out_phase_reg;
    assign m_tdata   = out_phase_reg
                     ? OUT_DW'({out_alpha_b_reg, out_gray_b_reg, out_row_b_reg, out_col_reg})
                     : OUT_DW'({out_alpha_a_reg, out_gray_a_reg, out_row_a_reg, out_col_reg});
    assign out_final = m_tready && m_tlast;

    // ready ripples back from the output; row-0 pixels retire in stage 1
    assign out_load = s2_valid_reg && (!out_valid_reg || out_final);
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !s2_valid_reg || out_load);
    assign s2_load  = s1_adv && s1_emit_reg;
    assign s_tready = !s1_valid_reg || s1_adv;

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= 1'b0;
            pd_reg[0]     <= '0;
            pd_reg[1]     <= '0;
            gd_reg[0]     <= '0;
            gd_reg[1]     <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                pd_reg[1] <= pd_reg[0];
                pd_reg[0] <= old_pix;
            end
            if (s2_load && s1_last_reg)
            begin
                gd_reg[1] <= gd_reg[0];
                gd_reg[0] <= g_above;
            end

            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (out_load)
                s2_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_phase_reg <= 1'b0;
            end
            else if (out_valid_reg && m_tready)
            begin
                if (m_tlast)
                    out_valid_reg <= 1'b0;
                else
                    out_phase_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cur_reg  <= s_tdata;
            s1_col_reg  <= col_count_reg;
            s1_row_reg  <= row_count_reg;
            s1_emit_reg <= row_count_reg != '0;
            s1_last_reg <= row_is_last;
        end
        if (s2_load)
        begin
            s2_rgb_reg       <= s1_cur_reg[23:0];
            s2_alpha_cur_reg <= s1_cur_reg[31:24];
            s2_alpha_old_reg <= old_pix[31:24];
            s2_g_above_reg   <= g_above;
            s2_g_ref_reg     <= g_ref;
            s2_col_reg       <= s1_col_reg;
            s2_row_reg       <= s1_row_reg;
            s2_last_reg      <= s1_last_reg;
        end
        if (out_load)
        begin
            out_pair_reg    <= s2_last_reg;
            out_col_reg     <= s2_col_reg;
            out_row_a_reg   <= s2_row_reg - RW'(1);
            out_row_b_reg   <= s2_row_reg;
            out_gray_a_reg  <= s2_g_above_reg;
            out_alpha_a_reg <= s2_alpha_old_reg;
            out_gray_b_reg  <= g_here;
            out_alpha_b_reg <= s2_alpha_cur_reg;
        end
    end

`ifndef ASSERT_OFF
    // stage 1 holds the pixel, with its store read data, in the cycle after the pixel transaction
    a_s1_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("stage 1 empty after pixel transaction");

    // the second result of a pair is the next row, same column
    a_pair_succession: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tlast
             && m_tdata[CW +: RW] == $past(m_tdata[CW +: RW]) + RW'(1)
             && m_tdata[CW-1:0] == $past(m_tdata[CW-1:0])))
        else $error("second result of a pair out of place");

    // second phase only exists for a two-result pixel
    a_phase_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_phase_reg) |-> out_pair_reg)
        else $error("second result shown for a single-result pixel");

    // row-0 pixels never reach the gray stage
    a_row0_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_emit_reg) |-> !s2_load)
        else $error("row-0 pixel entered stage 2");
`endif

endmodule
`default_nettype wire
